/* src/sstv_pkg.sv */
`default_nettype none
package sstv_pkg;

  // Token kinds
  localparam logic [3:0] K_SELECT = 4'd0;
  localparam logic [3:0] K_FROM   = 4'd1;
  localparam logic [3:0] K_WHERE  = 4'd2;
  localparam logic [3:0] K_COMMA  = 4'd3;
  localparam logic [3:0] K_EQUALS = 4'd4;
  localparam logic [3:0] K_AND    = 4'd5;
  localparam logic [3:0] K_OR     = 4'd6;
  localparam logic [3:0] K_SEMI   = 4'd7;
  localparam logic [3:0] K_NUMBER = 4'd8;
  localparam logic [3:0] K_STRING = 4'd9;

  // Grammar positions
  localparam logic [3:0] S_SELECT       = 4'd0;
  localparam logic [3:0] S_ITEM         = 4'd1;
  localparam logic [3:0] S_ITEM_CONT    = 4'd2;
  localparam logic [3:0] S_TABLE        = 4'd3;
  localparam logic [3:0] S_WHERE_OR_END = 4'd4;
  localparam logic [3:0] S_LHS          = 4'd5;
  localparam logic [3:0] S_OP           = 4'd6;
  localparam logic [3:0] S_RHS          = 4'd7;
  localparam logic [3:0] S_COND_CONT    = 4'd8;
  localparam logic [3:0] S_DONE         = 4'd9;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNEXP   = 2'd2;

  // Characters that classify token text
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Token position counter
  localparam int unsigned MAX_TOKENS = 1024;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned POS_CAP_I  = (MAX_TOKENS < 2047) ? MAX_TOKENS : 2047;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);

  localparam logic [7:0] ERR_MAX = 8'hFF;

endpackage
`default_nettype wire

/* src/sql_subset_token_validator.sv */
// SELECT-subset token validator. Takes one token per transfer and returns one
// result per token: status (accepted, invalid kind, unexpected here), the
// grammar position expected on arrival, the token index (saturating at
// MAX_TOKENS), a running saturating error count and an end-of-query
// incomplete flag. A token with end_of_query set closes the query and returns
// all state to the expect-SELECT position. Throughput is one token per clock
// while results are taken; the single result register loads with the grammar
// state update. in_ready stays high while the result register is empty or
// being drained, so a stalled consumer stalls input after one item.
`default_nettype none
module sql_subset_token_validator
  import sstv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [3:0]       in_token_kind,
  input  wire logic             in_has_text,
  input  wire logic [7:0]       in_first_char,
  input  wire logic [7:0]       in_second_char,
  input  wire logic             in_end_of_query,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_status,
  output logic [3:0]            out_expected_before,
  output logic [POS_W-1:0]      out_position,
  output logic                  out_incomplete,
  output logic [7:0]            out_errors_so_far,
  output logic                  out_query_ok
);

  // Grammar state
  logic [3:0]       state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       err_r, err_nxt;

  // Result register
  logic             out_valid_r;
  logic [1:0]       status_r, status_nxt;
  logic [3:0]       before_r;
  logic [POS_W-1:0] position_r;
  logic             incomplete_r, incomplete_nxt;
  logic [7:0]       errs_r;

  logic accept;
  logic is_str, is_star, is_lit, is_ident;
  logic allowed;
  logic [3:0] nx;
  logic [8:0] err_sum;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Token text classification
  always_comb begin
    is_str  = (in_token_kind == K_STRING) && in_has_text;
    is_star = is_str && (in_first_char == CH_STAR) && (in_second_char == CH_NUL);
    is_lit  = (in_token_kind == K_NUMBER) ||
              (is_str && (in_first_char inside {CH_SQUOTE, CH_DQUOTE, [CH_ZERO:CH_NINE]}));
    is_ident = is_str && (in_first_char != CH_NUL) &&
               !(in_first_char inside {CH_SQUOTE, CH_DQUOTE, CH_STAR, [CH_ZERO:CH_NINE]});
  end

  // Grammar transition
  always_comb begin
    allowed = 1'b0;
    nx      = state_r;
    case (state_r)
      S_SELECT: begin
        allowed = (in_token_kind == K_SELECT);
        nx      = S_ITEM;
      end
      S_ITEM: begin
        allowed = is_ident || is_star;
        nx      = S_ITEM_CONT;
      end
      S_ITEM_CONT: begin
        allowed = (in_token_kind == K_COMMA) || (in_token_kind == K_FROM);
        nx      = (in_token_kind == K_COMMA) ? S_ITEM : S_TABLE;
      end
      S_TABLE: begin
        allowed = is_ident;
        nx      = S_WHERE_OR_END;
      end
      S_WHERE_OR_END: begin
        allowed = (in_token_kind == K_WHERE) || (in_token_kind == K_SEMI);
        nx      = (in_token_kind == K_WHERE) ? S_LHS : S_DONE;
      end
      S_LHS: begin
        allowed = is_ident;
        nx      = S_OP;
      end
      S_OP: begin
        allowed = (in_token_kind == K_EQUALS);
        nx      = S_RHS;
      end
      S_RHS: begin
        allowed = is_lit;
        nx      = S_COND_CONT;
      end
      S_COND_CONT: begin
        allowed = (in_token_kind inside {K_AND, K_OR, K_SEMI});
        nx      = (in_token_kind == K_SEMI) ? S_DONE : S_LHS;
      end
      default: begin
        allowed = 1'b0;
        nx      = state_r;
      end
    endcase
  end

  // Status, error count and next state for this token
  always_comb begin
    status_nxt     = ST_OK;
    incomplete_nxt = 1'b0;
    state_nxt      = state_r;
    err_sum        = {1'b0, err_r};
    if (in_end_of_query) begin
      if (state_r != S_DONE) begin
        status_nxt     = ST_UNEXP;
        incomplete_nxt = 1'b1;
        err_sum        = {1'b0, err_r} + 9'd2;
      end
    end else if (in_token_kind > K_STRING) begin
      status_nxt = ST_INVALID;
      err_sum    = {1'b0, err_r} + 9'd1;
    end else if (!allowed) begin
      status_nxt = ST_UNEXP;
      err_sum    = {1'b0, err_r} + 9'd1;
    end else begin
      state_nxt = nx;
    end
    err_nxt = err_sum[8] ? ERR_MAX : err_sum[7:0];
    pos_nxt = (pos_r < POS_CAP) ? pos_r + POS_W'(1) : pos_r;
  end

  // Query state, cleared at end of query
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SELECT;
      pos_r   <= '0;
      err_r   <= '0;
    end else if (accept) begin
      if (in_end_of_query) begin
        state_r <= S_SELECT;
        pos_r   <= '0;
        err_r   <= '0;
      end else begin
        state_r <= state_nxt;
        pos_r   <= pos_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      before_r     <= state_r;
      position_r   <= pos_r;
      incomplete_r <= incomplete_nxt;
      errs_r       <= err_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_expected_before = before_r;
  assign out_position        = position_r;
  assign out_incomplete      = incomplete_r;
  assign out_errors_so_far   = errs_r;
  assign out_query_ok        = (errs_r == 8'd0);

endmodule
`default_nettype wire

/* src/sstv_checker.sv */
`default_nettype none
module sstv_checker
  import sstv_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [1:0]       out_status,
  input wire logic [3:0]       out_expected_before,
  input wire logic [POS_W-1:0] out_position,
  input wire logic             out_incomplete,
  input wire logic [7:0]       out_errors_so_far,
  input wire logic             out_query_ok
);

  // No result is shown straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_errors_so_far) && $stable(out_position))
    else $error("stalled result changed");

  // Query ok tracks the error count
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_query_ok == (out_errors_so_far == 8'd0))
    else $error("query_ok disagrees with error count");

  // Any error status has been counted
  a_err_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_errors_so_far != 8'd0)
    else $error("error status without error count");

  // Incomplete only with an unexpected end outside the done position
  a_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_incomplete |-> out_status == ST_UNEXP &&
      out_expected_before != S_DONE)
    else $error("incomplete flag inconsistent");

endmodule

bind sql_subset_token_validator sstv_checker u_sstv_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_expected_before (out_expected_before),
  .out_position        (out_position),
  .out_incomplete      (out_incomplete),
  .out_errors_so_far   (out_errors_so_far),
  .out_query_ok        (out_query_ok)
);
`default_nettype wire

/* verif/tb_sql_subset_token_validator.sv */
`default_nettype none
module tb_sql_subset_token_validator;
  import sstv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Marks a token that the grammar does not allow in the current position
  localparam logic [3:0] NO_MOVE = 4'd15;

  typedef struct packed {
    logic [3:0] kind;
    logic       has_text;
    logic [7:0] first_ch;
    logic [7:0] second_ch;
    logic       eoq;
  } token_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       prior_state;
    logic [POS_W-1:0] pos;
    logic             incomplete;
    logic [7:0]       errs;
    logic             ok;
  } verdict_t;

  typedef struct {
    token_t   tok;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [3:0]       in_token_kind;
  logic             in_has_text;
  logic [7:0]       in_first_char;
  logic [7:0]       in_second_char;
  logic             in_end_of_query;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       out_status;
  logic [3:0]       out_expected_before;
  logic [POS_W-1:0] out_position;
  logic             out_incomplete;
  logic [7:0]       out_errors_so_far;
  logic             out_query_ok;

  // Predictor state
  logic [3:0]       gram_state;
  logic [POS_W-1:0] tok_index;
  logic [7:0]       err_tally;

  verdict_t verdicts_due[$];
  dir_row_t dir_rows[$];
  int       mismatches;
  int       sent;
  bit       quiet;
  bit       hold_req;

  sql_subset_token_validator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_token_kind       (in_token_kind),
    .in_has_text         (in_has_text),
    .in_first_char       (in_first_char),
    .in_second_char      (in_second_char),
    .in_end_of_query     (in_end_of_query),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_expected_before (out_expected_before),
    .out_position        (out_position),
    .out_incomplete      (out_incomplete),
    .out_errors_so_far   (out_errors_so_far),
    .out_query_ok        (out_query_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_sql_subset_token_validator: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Token classification and grammar
  // ---------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit text_is_star(token_t t);
    return t.kind == K_STRING && t.has_text && t.first_ch == CH_STAR && t.second_ch == CH_NUL;
  endfunction

  function automatic bit text_is_literal(token_t t);
    if (t.kind == K_NUMBER) return 1'b1;
    return t.kind == K_STRING && t.has_text &&
           (t.first_ch == CH_SQUOTE || t.first_ch == CH_DQUOTE || is_digit(t.first_ch));
  endfunction

  function automatic bit text_is_name(token_t t);
    return t.kind == K_STRING && t.has_text && t.first_ch != CH_NUL &&
           t.first_ch != CH_SQUOTE && t.first_ch != CH_DQUOTE &&
           t.first_ch != CH_STAR && !is_digit(t.first_ch);
  endfunction

  function automatic logic [3:0] grammar_next(logic [3:0] s, token_t t);
    case (s)
      S_SELECT:       return (t.kind == K_SELECT) ? S_ITEM : NO_MOVE;
      S_ITEM:         return (text_is_name(t) || text_is_star(t)) ? S_ITEM_CONT : NO_MOVE;
      S_ITEM_CONT: begin
        if (t.kind == K_COMMA) return S_ITEM;
        if (t.kind == K_FROM) return S_TABLE;
        return NO_MOVE;
      end
      S_TABLE:        return text_is_name(t) ? S_WHERE_OR_END : NO_MOVE;
      S_WHERE_OR_END: begin
        if (t.kind == K_WHERE) return S_LHS;
        if (t.kind == K_SEMI) return S_DONE;
        return NO_MOVE;
      end
      S_LHS:          return text_is_name(t) ? S_OP : NO_MOVE;
      S_OP:           return (t.kind == K_EQUALS) ? S_RHS : NO_MOVE;
      S_RHS:          return text_is_literal(t) ? S_COND_CONT : NO_MOVE;
      S_COND_CONT: begin
        if (t.kind == K_AND || t.kind == K_OR) return S_LHS;
        if (t.kind == K_SEMI) return S_DONE;
        return NO_MOVE;
      end
      default:        return NO_MOVE;
    endcase
  endfunction

  function automatic logic [7:0] sat_inc(logic [7:0] x);
    return (x == ERR_MAX) ? x : x + 8'd1;
  endfunction

  // Works out the result for one token and advances the predictor state
  function automatic verdict_t predict_verdict(token_t t);
    verdict_t   v;
    logic [3:0] nxt;
    v = '0;
    v.status = ST_OK;
    v.prior_state = gram_state;
    v.pos = tok_index;
    if (t.eoq) begin
      // end short of done: unexpected end plus incomplete query
      if (gram_state != S_DONE) begin
        v.status = ST_UNEXP;
        v.incomplete = 1'b1;
        err_tally = sat_inc(sat_inc(err_tally));
      end
    end else if (t.kind > K_STRING) begin
      v.status = ST_INVALID;
      err_tally = sat_inc(err_tally);
    end else begin
      nxt = grammar_next(gram_state, t);
      if (nxt == NO_MOVE) begin
        v.status = ST_UNEXP;
        err_tally = sat_inc(err_tally);
      end else begin
        gram_state = nxt;
      end
    end
    v.errs = err_tally;
    v.ok = (err_tally == 8'd0);
    if (t.eoq) begin
      gram_state = S_SELECT;
      tok_index = '0;
      err_tally = '0;
    end else if (tok_index < POS_CAP) begin
      tok_index = tok_index + POS_W'(1);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Token builders
  // ---------------------------------------------------------------------------
  function automatic token_t tk(logic [3:0] kind, logic txt, logic [7:0] c0, logic [7:0] c1,
                                logic eoq);
    token_t t;
    t.kind = kind;
    t.has_text = txt;
    t.first_ch = c0;
    t.second_ch = c1;
    t.eoq = eoq;
    return t;
  endfunction

  function automatic verdict_t vd(logic [1:0] st, logic [3:0] bf, int pos, logic inc, int errs,
                                  logic ok);
    verdict_t v;
    v.status = st;
    v.prior_state = bf;
    v.pos = pos[POS_W-1:0];
    v.incomplete = inc;
    v.errs = errs[7:0];
    v.ok = ok;
    return v;
  endfunction

  // keyword with random, ignored text fields
  function automatic token_t kw(logic [3:0] kind);
    return tk(kind, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 1'b0);
  endfunction

  function automatic token_t name_tok();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_STAR || is_digit(c));
    return tk(K_STRING, 1'b1, c, ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom), 1'b0);
  endfunction

  function automatic token_t item_tok();
    if ($urandom_range(0, 2) == 0) return tk(K_STRING, 1'b1, CH_STAR, CH_NUL, 1'b0);
    return name_tok();
  endfunction

  function automatic token_t literal_tok();
    case ($urandom_range(0, 3))
      0:       return kw(K_NUMBER);
      1:       return tk(K_STRING, 1'b1, CH_SQUOTE, 8'($urandom), 1'b0);
      2:       return tk(K_STRING, 1'b1, CH_DQUOTE, 8'($urandom), 1'b0);
      default: return tk(K_STRING, 1'b1, 8'($urandom_range(CH_ZERO, CH_NINE)), 8'($urandom),
                         1'b0);
    endcase
  endfunction

  // anything at all, biased towards the characters that steer classification
  function automatic token_t noise_tok();
    logic [7:0] c0;
    case ($urandom_range(0, 7))
      0:       c0 = CH_NUL;
      1:       c0 = CH_STAR;
      2:       c0 = CH_SQUOTE;
      3:       c0 = CH_DQUOTE;
      4:       c0 = 8'($urandom_range(CH_ZERO, CH_NINE));
      default: c0 = 8'($urandom);
    endcase
    return tk(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), c0,
              ($urandom_range(0, 1) == 0) ? CH_NUL : 8'($urandom), 1'b0);
  endfunction

  // Well-formed query with random content, at times a stray token after it, optionally damaged, then end marker
  function automatic void add_query(ref token_t q[$], input int n_items, input int n_conds,
                                    input int damage_pct);
    int cut;
    q.push_back(kw(K_SELECT));
    for (int i = 0; i < n_items; i++) begin
      if (i != 0) q.push_back(kw(K_COMMA));
      q.push_back(item_tok());
    end
    q.push_back(kw(K_FROM));
    q.push_back(name_tok());
    if (n_conds > 0) begin
      q.push_back(kw(K_WHERE));
      for (int j = 0; j < n_conds; j++) begin
        if (j != 0) q.push_back(kw($urandom_range(0, 1) ? K_AND : K_OR));
        q.push_back(name_tok());
        q.push_back(kw(K_EQUALS));
        q.push_back(literal_tok());
      end
    end
    q.push_back(kw(K_SEMI));
    if ($urandom_range(0, 9) == 0) q.push_back(kw(4'($urandom_range(0, 9))));
    if ($urandom_range(0, 99) < damage_pct) begin
      if ($urandom_range(0, 1) == 0) begin
        q[$urandom_range(0, q.size() - 1)] = noise_tok();
      end else begin
        cut = $urandom_range(0, q.size() - 1);
        while (q.size() > cut) void'(q.pop_back());
      end
    end
    q.push_back(tk(4'($urandom), 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 1'b1));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: predict, then offer the token until the transfer happens
  // ---------------------------------------------------------------------------
  task automatic send_token(input token_t t, input bit typed, input verdict_t want);
    verdict_t guess;
    guess = predict_verdict(t);
    verdicts_due.push_back(typed ? want : guess);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_token_kind <= t.kind;
    in_has_text <= t.has_text;
    in_first_char <= t.first_ch;
    in_second_char <= t.second_ch;
    in_end_of_query <= t.eoq;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each transfer, stall in bursts
  // ---------------------------------------------------------------------------
  task automatic check_verdict();
    verdict_t w;
    if (verdicts_due.size() == 0) begin
      $error("result with nothing expected: status %0d position %0d", out_status, out_position);
      mismatches++;
    end else begin
      w = verdicts_due.pop_front();
      if (out_status !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, out_status);
        mismatches++;
      end
      if (out_expected_before !== w.prior_state) begin
        $error("expected_before: expected %0d, got %0d", w.prior_state, out_expected_before);
        mismatches++;
      end
      if (out_position !== w.pos) begin
        $error("position: expected %0d, got %0d", w.pos, out_position);
        mismatches++;
      end
      if (out_incomplete !== w.incomplete) begin
        $error("incomplete: expected %0d, got %0d", w.incomplete, out_incomplete);
        mismatches++;
      end
      if (out_errors_so_far !== w.errs) begin
        $error("errors_so_far: expected %0d, got %0d", w.errs, out_errors_so_far);
        mismatches++;
      end
      if (out_query_ok !== w.ok) begin
        $error("query_ok: expected %0d, got %0d", w.ok, out_query_ok);
        mismatches++;
      end
    end
  endtask

  initial begin : result_side
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_verdict();
      // long hold-off so the block fills and back-pressures its input
      if (hold_req) begin
        stall_left = 300;
        hold_req = 1'b0;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : token_side
    token_t qtoks[$];
    token_t t;
    int     qn;
    bit     held;
    mismatches = 0;
    sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    held = 1'b0;
    qn = 0;
    gram_state = S_SELECT;
    tok_index = '0;
    err_tally = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_token_kind <= '0;
    in_has_text <= 1'b0;
    in_first_char <= '0;
    in_second_char <= '0;
    in_end_of_query <= 1'b0;

    // Directed rows: full grammar walk, then the error and end cases
    dir_rows.push_back(dir_row_t'{tk(K_SELECT, 0, 0, 0, 0), 1'b1,
                                  vd(ST_OK, S_SELECT, 0, 0, 0, 1)});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 1, CH_STAR, CH_NUL, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_COMMA, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 1, "a", "b", 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_FROM, 1, 8'hFF, 8'hFF, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 1, 8'hFF, 8'hFF, 0), 1'b1,
                                  vd(ST_OK, S_TABLE, 5, 0, 0, 1)});
    dir_rows.push_back(dir_row_t'{tk(K_WHERE, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 1, "x", CH_NUL, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_EQUALS, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_NUMBER, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_OR, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 1, "y", CH_NUL, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_EQUALS, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 1, CH_SQUOTE, "q", 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_SEMI, 0, 0, 0, 0), 1'b0, '0});
    // token after the semicolon, then an invalid kind, then a clean end
    dir_rows.push_back(dir_row_t'{tk(K_AND, 0, 0, 0, 0), 1'b1,
                                  vd(ST_UNEXP, S_DONE, 15, 0, 1, 0)});
    dir_rows.push_back(dir_row_t'{tk(4'd15, 1, 8'hFF, 8'hFF, 0), 1'b1,
                                  vd(ST_INVALID, S_DONE, 16, 0, 2, 0)});
    dir_rows.push_back(dir_row_t'{tk(K_SELECT, 0, 0, 0, 1), 1'b1,
                                  vd(ST_OK, S_DONE, 17, 0, 2, 0)});
    // empty query: unexpected end counts twice
    dir_rows.push_back(dir_row_t'{tk(K_SELECT, 0, 0, 0, 1), 1'b1,
                                  vd(ST_UNEXP, S_SELECT, 0, 1, 2, 0)});
    // items that look close to a select item but are not one
    dir_rows.push_back(dir_row_t'{tk(K_SELECT, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 0, "a", CH_NUL, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 1, CH_NUL, CH_NUL, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 1, CH_STAR, "a", 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(K_STRING, 1, CH_NINE, CH_NUL, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(4'd10, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tk(4'd15, 1, 8'hFF, 8'hFF, 1), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_token(dir_rows[i].tok, dir_rows[i].typed, dir_rows[i].want);

    // Random queries: mostly well-formed, some damaged, some pure noise
    while (sent < 1800) begin
      qtoks.delete();
      if (qn == 2) begin
        // long WHERE chain drives the token index into saturation
        add_query(qtoks, 1, 260, 0);
      end else if (qn == 5) begin
        // a run of invalid kinds saturates the error count
        for (int i = 0; i < 300; i++) begin
          t = noise_tok();
          t.kind = 4'($urandom_range(10, 15));
          qtoks.push_back(t);
        end
        qtoks.push_back(tk(4'($urandom), 1'b1, 8'($urandom), 8'($urandom), 1'b1));
      end else if ($urandom_range(0, 9) < 7) begin
        add_query(qtoks, $urandom_range(1, 4), $urandom_range(0, 3), 25);
      end else begin
        repeat ($urandom_range(1, 12)) qtoks.push_back(noise_tok());
        qtoks.push_back(tk(4'($urandom), 1'($urandom_range(0, 1)), 8'($urandom),
                           8'($urandom), 1'b1));
      end
      qn++;
      foreach (qtoks[i]) begin
        if (!held && sent >= 1500) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (sent >= 1600) quiet = 1'b1;
        send_token(qtoks[i], 1'b0, '0);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_sql_subset_token_validator: PASS");
    end else begin
      $display("tb_sql_subset_token_validator: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
